[rtl/ring_queue_with_address_match_core_assert.svh]
// Assertion macros for the ring queue with address match.
// Used by rqam_store; expects clk and arst_n in the including scope.
`ifndef RING_QUEUE_WITH_ADDRESS_MATCH_CORE_ASSERT_SVH
`define RING_QUEUE_WITH_ADDRESS_MATCH_CORE_ASSERT_SVH

// same-cycle implication
`define RQAM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rqam: same-cycle check failed");

// next-cycle implication
`define RQAM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rqam: next-cycle check failed");

`endif

[rtl/rqam_pkg.sv]
// Shared types and constants for the ring queue with address match.
// No dependencies; imported by every rqam module and the core.
package rqam_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int ADDR_W = 64;
	localparam int SID_W  = 16;
	localparam int OWN_W  = 4;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [SID_W-1:0]  sid_t;
	typedef logic [OWN_W-1:0]  own_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	typedef enum logic [1:0] {
		OP_CHECK  = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef struct packed {
		op_t   op;
		addr_t line_addr;
		addr_t byte_addr;
		sid_t  sid;
		own_t  own;
	} req_t;

	// search outcome: first match from head
	typedef struct packed {
		logic found;
		idx_t idx;
	} srch_t;

	// per-item status from the store
	typedef struct packed {
		logic err;
		logic merge;
		cnt_t count;
	} stat_t;

	function automatic idx_t ring_next(input idx_t p);
		ring_next = (p == idx_t'(DEPTH - 1)) ? '0 : idx_t'(p + 1'b1);
	endfunction

endpackage

[rtl/rqam_search.sv]
// Associative lookup: parallel comparators plus a circular priority pick.
// Depends on rqam_pkg.
module rqam_search
	import rqam_pkg::*;
(
	input  req_t  req,
	input  logic  line_mode,
	input  addr_t slot_line [DEPTH],
	input  addr_t slot_byte [DEPTH],
	input  sid_t  slot_sid  [DEPTH],
	input  idx_t  head,
	input  cnt_t  count,
	output srch_t srch
);

	logic [DEPTH-1:0] match;
	logic [DEPTH-1:0] rot;
	logic [DEPTH-1:0] first;
	idx_t             off;

	// one comparator per slot, qualified by occupancy
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			match[i] = ({1'b0, idx_t'(idx_t'(i) - head)} < count) &&
				(line_mode ? ((slot_line[i] == req.line_addr) && (slot_sid[i] == req.sid))
				           : (slot_byte[i] == req.byte_addr));
		end
	end

	// rotate so bit 0 is the oldest entry, isolate lowest set bit, encode
	always_comb begin
		for (int k = 0; k < DEPTH; k++) begin
			rot[k] = match[idx_t'(idx_t'(k) + head)];
		end
		first = rot & (~rot + 1'b1);
		off   = '0;
		for (int k = 0; k < DEPTH; k++) begin
			if (first[k]) begin
				off = off | idx_t'(k);
			end
		end
		srch.found = |rot;
		srch.idx   = idx_t'(head + off);
	end

endmodule

[rtl/rqam_store.sv]
// Slot storage, merged marks, head/tail pointers and occupancy count.
// Depends on rqam_pkg and the assertion macro header.
`include "ring_queue_with_address_match_core_assert.svh"
module rqam_store
	import rqam_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  vld,
	input  req_t  req,
	input  logic  line_mode,
	input  srch_t srch,
	output addr_t slot_line [DEPTH],
	output addr_t slot_byte [DEPTH],
	output sid_t  slot_sid  [DEPTH],
	output idx_t  head_q,
	output cnt_t  count_q,
	output stat_t stat
);

	own_t             own_q [DEPTH];
	logic [DEPTH-1:0] merged_q;
	idx_t             tail_q;
	logic             full;
	logic             empty;
	logic             do_add;
	logic             do_rem;
	logic             do_merge;
	logic             err;
	cnt_t             count_d;

	always_comb begin
		full     = (count_q == cnt_t'(DEPTH));
		empty    = (count_q == '0);
		do_add   = 1'b0;
		do_rem   = 1'b0;
		do_merge = 1'b0;
		err      = 1'b0;
		if (vld) begin
			case (req.op)
				OP_CHECK: begin
					do_merge = line_mode && srch.found && (own_q[srch.idx] != req.own);
				end
				OP_ADD: begin
					do_add = !full;
					err    = full;
				end
				OP_REMOVE: begin
					do_rem = !empty;
					err    = empty;
				end
				default: begin
				end
			endcase
		end
		count_d = count_q;
		if (do_add) begin
			count_d = cnt_t'(count_q + 1'b1);
		end else if (do_rem) begin
			count_d = cnt_t'(count_q - 1'b1);
		end
		stat.err   = err;
		stat.merge = do_merge;
		stat.count = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			merged_q <= '0;
		end else begin
			count_q <= count_d;
			if (do_add) begin
				tail_q           <= ring_next(tail_q);
				merged_q[tail_q] <= 1'b0;
			end
			if (do_rem) begin
				head_q           <= ring_next(head_q);
				merged_q[head_q] <= 1'b0;
			end
			if (do_merge) begin
				merged_q[srch.idx] <= 1'b1;
			end
		end
	end

	// payload: written at tail, no reset
	always_ff @(posedge clk) begin
		if (do_add) begin
			slot_line[tail_q] <= req.line_addr;
			slot_byte[tail_q] <= req.byte_addr;
			slot_sid[tail_q]  <= req.sid;
			own_q[tail_q]     <= req.own;
		end
	end

	`RQAM_ASSERT_SAME(a_count_range, 1'b1, count_q <= cnt_t'(DEPTH))
	`RQAM_ASSERT_SAME(a_ring_consistent, 1'b1, tail_q == idx_t'(head_q + count_q[IDX_W-1:0]))
	`RQAM_ASSERT_NEXT(a_merge_marked, do_merge, merged_q[$past(srch.idx)])
	`RQAM_ASSERT_SAME(a_err_no_change, err, !do_add && !do_rem && !do_merge)

endmodule

[rtl/ring_queue_with_address_match_core.sv]
// Top level of the ring queue with address match: input and result registers,
// match-mode register, lookup and storage. Depends on rqam_pkg, rqam_search, rqam_store.
//
// channel   direction  handshake                     payload
// request   in         start (taken when !busy)      mode, line_address, byte_address,
//                                                    space_id, owner
// result    out        done (one-cycle strobe)       hit, hit_index, cross_owner_merge,
//                                                    fill_count, op_error
// config    in         cfg_wr_en                     cfg_wr_data (match mode)
//
// One item per cycle: busy is never raised, a transfer may follow every cycle.
// Each item passes the request register, then one pass of compare / priority pick / update
// into the result register. Queue state is updated at the same edge as the result register,
// so the next request already sees it. Reset clears pointers, count, merged marks and sets
// line-address matching. The receiver cannot stall; each result is shown once.
module ring_queue_with_address_match_core
	import rqam_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [1:0]        mode,
	input  addr_t             line_address,
	input  addr_t             byte_address,
	input  sid_t              space_id,
	input  own_t              owner,
	input  logic              cfg_wr_en,
	input  logic              cfg_wr_data,
	output logic              done,
	output logic              hit,
	output idx_t              hit_index,
	output logic              cross_owner_merge,
	output cnt_t              fill_count,
	output logic              op_error
);

	// request stage
	logic  vld_s1;
	req_t  req_s1;

	// config: 1 = line address + space id, 0 = byte address
	logic  line_mode_q;

	addr_t slot_line [DEPTH];
	addr_t slot_byte [DEPTH];
	sid_t  slot_sid  [DEPTH];
	idx_t  head;
	cnt_t  count;
	srch_t srch;
	stat_t stat;
	logic  is_check;

	// fully pipelined; never holds off a request
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			line_mode_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1.op        <= op_t'(mode);
			req_s1.line_addr <= line_address;
			req_s1.byte_addr <= byte_address;
			req_s1.sid       <= space_id;
			req_s1.own       <= owner;
		end
	end

	rqam_search u_search (
		.req       (req_s1),
		.line_mode (line_mode_q),
		.slot_line (slot_line),
		.slot_byte (slot_byte),
		.slot_sid  (slot_sid),
		.head      (head),
		.count     (count),
		.srch      (srch)
	);

	rqam_store u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld       (vld_s1),
		.req       (req_s1),
		.line_mode (line_mode_q),
		.srch      (srch),
		.slot_line (slot_line),
		.slot_byte (slot_byte),
		.slot_sid  (slot_sid),
		.head_q    (head),
		.count_q   (count),
		.stat      (stat)
	);

	// hit fields only mean something for a check
	assign is_check = (req_s1.op == OP_CHECK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	// result register: payload, no reset
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			hit               <= is_check && srch.found;
			hit_index         <= (is_check && srch.found) ? srch.idx : '0;
			cross_owner_merge <= stat.merge;
			fill_count        <= stat.count;
			op_error          <= stat.err;
		end
	end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ring_queue_with_address_match_core: directed table, then random phases.
// Depends on rqam_pkg and the core; keeps its own model of the ring to predict every result.
module testbench;
	import rqam_pkg::*;

	// Mode 3 is not an operation; the core must pass it through with no effect.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	// match_mode register values
	localparam logic MATCH_BYTE = 1'b0;
	localparam logic MATCH_LINE = 1'b1;
	// generous bound on the length of the whole run
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 112;

	// one expected result, field order as on the result ports
	typedef struct packed {
		logic hit;
		idx_t idx;
		logic merge;
		cnt_t count;
		logic err;
	} res_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// directed row: rep transfers, addresses stepping by one per transfer
	typedef struct {
		row_kind_t kind;
		int rep;
		logic [1:0] op;
		addr_t la;
		addr_t ba;
		sid_t s;
		own_t o;
		logic typed;
		res_t want;
	} row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic [1:0] mode;
	addr_t line_address;
	addr_t byte_address;
	sid_t space_id;
	own_t owner;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic done;
	logic hit;
	idx_t hit_index;
	logic cross_owner_merge;
	cnt_t fill_count;
	logic op_error;

	ring_queue_with_address_match_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.line_address(line_address),
		.byte_address(byte_address),
		.space_id(space_id),
		.owner(owner),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.hit(hit),
		.hit_index(hit_index),
		.cross_owner_merge(cross_owner_merge),
		.fill_count(fill_count),
		.op_error(op_error)
	);

	// ---------------------------------------------------------------------
	// Shadow ring: our own copy of the queue contents and the match mode.
	// ---------------------------------------------------------------------
	addr_t slot_line [DEPTH];
	addr_t slot_byte [DEPTH];
	sid_t slot_sid [DEPTH];
	own_t slot_own [DEPTH];
	logic slot_merged [DEPTH];
	idx_t ring_head;
	idx_t ring_tail;
	int ring_fill;
	logic ring_match;

	res_t pending_results [$];	// results owed by the core, oldest first
	int mismatches;
	int result_count;
	int cycle_count;

	// typed-in expectation for the transfer currently on the request port
	logic typed_on;
	res_t typed_res;

	// address pools so that checks and adds collide often
	addr_t line_pool [8];
	addr_t byte_pool [8];
	sid_t sid_pool [4];

	row_t directed [$];

	// Apply one operation to the shadow ring and return what the core must report.
	// Index arithmetic wraps on its own since the ring is a power of two deep.
	function automatic res_t ring_apply(input logic [1:0] op, input addr_t la, input addr_t ba,
			input sid_t s, input own_t o);
		res_t r;
		idx_t p;
		logic m;
		logic found;
		r = '0;
		case (op)
			OP_CHECK: begin
				p = ring_head;
				found = 1'b0;
				for (int k = 0; k < ring_fill; k++) begin
					if (!found) begin
						if (ring_match == MATCH_BYTE)
							m = (slot_byte[p] == ba);
						else
							m = (slot_line[p] == la) && (slot_sid[p] == s);
						if (m) begin
							found = 1'b1;
							r.hit = 1'b1;
							r.idx = p;
							if (ring_match == MATCH_LINE && slot_own[p] != o) begin
								slot_merged[p] = 1'b1;
								r.merge = 1'b1;
							end
						end
						p = idx_t'(p + 1);
					end
				end
			end
			OP_ADD: begin
				if (ring_fill >= DEPTH) begin
					r.err = 1'b1;
				end else begin
					slot_line[ring_tail] = la;
					slot_byte[ring_tail] = ba;
					slot_sid[ring_tail] = s;
					slot_own[ring_tail] = o;
					slot_merged[ring_tail] = 1'b0;
					ring_fill++;
					ring_tail = idx_t'(ring_tail + 1);
				end
			end
			OP_REMOVE: begin
				if (ring_fill == 0) begin
					r.err = 1'b1;
				end else begin
					slot_merged[ring_head] = 1'b0;
					ring_fill--;
					ring_head = idx_t'(ring_head + 1);
				end
			end
			default: ;	// unused mode: no effect
		endcase
		r.count = cnt_t'(ring_fill);
		return r;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on result %0d, %s: got %0h, want %0h", result_count, field, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------------
	// Clock, cycle limit
	// ---------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("ring_queue_with_address_match_core regression: fail");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Monitor: everything happens on the rising edge, on pre-edge values.
	// Results are checked before the new transfer is predicted; a result passes the request
	// register and then the result register, so the two never refer to the same item anyway.
	// ---------------------------------------------------------------------
	res_t got_res;
	res_t want_res;
	res_t next_res;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1) begin
				got_res = '{hit, hit_index, cross_owner_merge, fill_count, op_error};
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result", 64'd1, 64'd0);
				end else begin
					want_res = pending_results.pop_front();
					if (got_res.hit !== want_res.hit)
						report_mismatch("hit", 64'(got_res.hit), 64'(want_res.hit));
					if (got_res.idx !== want_res.idx)
						report_mismatch("hit_index", 64'(got_res.idx), 64'(want_res.idx));
					if (got_res.merge !== want_res.merge)
						report_mismatch("cross_owner_merge", 64'(got_res.merge),
							64'(want_res.merge));
					if (got_res.count !== want_res.count)
						report_mismatch("fill_count", 64'(got_res.count), 64'(want_res.count));
					if (got_res.err !== want_res.err)
						report_mismatch("op_error", 64'(got_res.err), 64'(want_res.err));
				end
				result_count++;
			end
			if (cfg_wr_en)
				ring_match = cfg_wr_data;
			if (start && busy === 1'b0) begin
				next_res = ring_apply(mode, line_address, byte_address, space_id, owner);
				// typed rows still step the shadow ring, but are held to the typed value
				pending_results.push_back(typed_on ? typed_res : next_res);
			end
		end
	end

	// ---------------------------------------------------------------------
	// Driver tasks. Inputs only change on the falling edge.
	// ---------------------------------------------------------------------

	// Present one request and wait for the edge that takes it; start stays
	// high so a back-to-back transfer can follow at the next falling edge.
	task automatic send_request(input logic [1:0] op, input addr_t la, input addr_t ba,
			input sid_t s, input own_t o, input logic use_typed, input res_t typed);
		@(negedge clk);
		start = 1'b1;
		mode = op;
		line_address = la;
		byte_address = ba;
		space_id = s;
		owner = o;
		typed_on = use_typed;
		typed_res = typed;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic hold_off(input int cycles);
		@(negedge clk);
		start = 1'b0;
		repeat (cycles - 1) @(negedge clk);
	endtask

	// stop sending and wait for every owed result
	task automatic drain_results();
		@(negedge clk);
		start = 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// match_mode only changes with the core idle
	task automatic write_match_mode(input logic value);
		drain_results();
		repeat (2) @(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = value;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic add_row(input row_kind_t kind, input int rep, input logic [1:0] op,
			input addr_t la, input addr_t ba, input sid_t s, input own_t o,
			input logic typed, input res_t want);
		row_t r;
		r.kind = kind;
		r.rep = rep;
		r.op = op;
		r.la = la;
		r.ba = ba;
		r.s = s;
		r.o = o;
		r.typed = typed;
		r.want = want;
		directed.push_back(r);
	endtask

	function automatic addr_t rand_addr();
		return {$urandom, $urandom};
	endfunction

	// Random request. Checks mostly aim at live entries, some with a near miss;
	// the rest draw from small pools or are fully random.
	task automatic random_request(input int add_pct, output logic [1:0] op, output addr_t la,
			output addr_t ba, output sid_t s, output own_t o);
		int r;
		int pick;
		idx_t slot;
		r = $urandom_range(0, 99);
		if (r < 3)
			op = OP_UNUSED;
		else if (r < 48)
			op = OP_CHECK;
		else
			op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_REMOVE;
		o = own_t'($urandom);
		pick = $urandom_range(0, 9);
		if (op == OP_CHECK && ring_fill != 0 && pick < 6) begin
			slot = idx_t'(ring_head + $urandom_range(0, ring_fill - 1));
			la = slot_line[slot];
			ba = slot_byte[slot];
			s = slot_sid[slot];
			if (pick == 0)
				s = s ^ sid_t'(1 << $urandom_range(0, SID_W - 1));
			if (pick == 1)
				la = la ^ (addr_t'(1) << $urandom_range(0, ADDR_W - 1));
			if (pick == 2)
				ba = ba ^ (addr_t'(1) << $urandom_range(0, ADDR_W - 1));
			if (pick > 3)
				o = slot_own[slot];	// same owner: hit without merge
		end else if (pick < 8) begin
			la = line_pool[$urandom_range(0, 7)];
			ba = byte_pool[$urandom_range(0, 7)];
			s = sid_pool[$urandom_range(0, 3)];
		end else begin
			la = rand_addr();
			ba = rand_addr();
			s = sid_t'($urandom);
		end
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		logic [1:0] op;
		addr_t la;
		addr_t ba;
		sid_t s;
		own_t o;
		int idle_pct;
		int add_pct;
		row_t row;

		arst_n = 1'b0;
		start = 1'b0;
		mode = OP_CHECK;
		line_address = '0;
		byte_address = '0;
		space_id = '0;
		owner = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = MATCH_LINE;
		typed_on = 1'b0;
		typed_res = '0;
		mismatches = 0;
		result_count = 0;
		cycle_count = 0;

		// shadow ring after reset; never-written slots are never read
		for (int i = 0; i < DEPTH; i++) begin
			slot_line[i] = '0;
			slot_byte[i] = '0;
			slot_sid[i] = '0;
			slot_own[i] = '0;
			slot_merged[i] = 1'b0;
		end
		ring_head = '0;
		ring_tail = '0;
		ring_fill = 0;
		ring_match = MATCH_LINE;

		line_pool[0] = '0;
		line_pool[7] = '1;
		byte_pool[0] = '0;
		byte_pool[7] = '1;
		for (int i = 1; i < 7; i++) begin
			line_pool[i] = rand_addr();
			byte_pool[i] = rand_addr();
		end
		sid_pool[0] = '0;
		sid_pool[1] = '1;
		sid_pool[2] = sid_t'($urandom);
		sid_pool[3] = sid_t'($urandom);

		// Directed table. Typed expectations: hit, index, merge, count, error.
		// empty queue: remove flagged, check misses, unused mode does nothing
		add_row(ROW_ITEM, 1, OP_REMOVE, '0, '0, '0, '0, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0, 1'b1});
		add_row(ROW_ITEM, 1, OP_CHECK, '0, '0, '0, '0, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0, 1'b0});
		add_row(ROW_ITEM, 1, OP_UNUSED, '1, '1, '1, '1, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd0, 1'b0});
		// all-ones and all-zeros entries
		add_row(ROW_ITEM, 1, OP_ADD, '1, '1, '1, '1, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd1, 1'b0});
		add_row(ROW_ITEM, 1, OP_ADD, '0, '0, '0, '0, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd2, 1'b0});
		// line mode: same owner, other owner (merge), space id mismatch
		add_row(ROW_ITEM, 1, OP_CHECK, '0, 64'h55, '0, '0, 1'b0, '0);
		add_row(ROW_ITEM, 1, OP_CHECK, '1, 64'h55, '1, '0, 1'b0, '0);
		add_row(ROW_ITEM, 1, OP_CHECK, '1, '1, '0, '1, 1'b0, '0);
		// fill to the brim, then one add too many
		add_row(ROW_ITEM, 14, OP_ADD, 64'h100, 64'h1000, 16'd5, 4'd3, 1'b0, '0);
		add_row(ROW_ITEM, 1, OP_ADD, '1, '1, '1, '1, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd16, 1'b1});
		add_row(ROW_ITEM, 1, OP_UNUSED, '0, '0, '0, '0, 1'b1, '{1'b0, 4'd0, 1'b0, 5'd16, 1'b0});
		add_row(ROW_ITEM, 1, OP_CHECK, 64'h10d, '0, 16'd5, 4'd3, 1'b0, '0);
		// byte mode: line and owner play no part
		add_row(ROW_CFG, 1, OP_CHECK, '0, '0, '0, '0, MATCH_BYTE, '0);
		add_row(ROW_ITEM, 1, OP_CHECK, '0, '1, '0, 4'd9, 1'b0, '0);
		add_row(ROW_ITEM, 1, OP_CHECK, 64'h77, 64'h1005, 16'd1, 4'd0, 1'b0, '0);
		add_row(ROW_ITEM, 1, OP_CHECK, 64'h105, 64'hdead, 16'd5, 4'd3, 1'b0, '0);

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i]) begin
			row = directed[i];
			if (row.kind == ROW_CFG) begin
				write_match_mode(row.typed);
			end else begin
				for (int k = 0; k < row.rep; k++)
					send_request(row.op, row.la + addr_t'(k), row.ba + addr_t'(k), row.s, row.o,
						row.typed, row.want);
			end
		end

		// Random phases: each starts idle with a new match mode, and mixes
		// fill-heavy, drain-heavy and balanced traffic so the ring hits
		// both full and empty and wraps many times.
		for (int p = 0; p < PHASES; p++) begin
			write_match_mode(p[0] ? MATCH_BYTE : MATCH_LINE);
			case (p % 4)
				0: idle_pct = 0;
				1: idle_pct = 56;
				2: idle_pct = 16;
				default: idle_pct = 56;
			endcase
			case (p % 3)
				0: add_pct = 75;
				1: add_pct = 25;
				default: add_pct = 50;
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// every cycle idles with odds idle_pct, so idle_pct is the idle share
				while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
					hold_off(1);
				// mid-phase pause until the core has caught up completely
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain_results();
				random_request(add_pct, op, la, ba, s, o);
				send_request(op, la, ba, s, o, 1'b0, '0);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);

		if (mismatches == 0)
			$display("ring_queue_with_address_match_core regression: pass");
		else
			$display("ring_queue_with_address_match_core regression: fail");
		$finish;
	end

endmodule
